// File: hw/rtl/mbbc_pkg.sv
// mbbc_pkg: widths, codes, reset values and divider handshake types
// for the metronome bar and beat counter; used by mbbc_div and the top level.
// No dependencies.
package mbbc_pkg;

    // field and register widths
    localparam int SR_W       = 18;
    localparam int TEMPO_W    = 17;
    localparam int BPB_W      = 6;
    localparam int REQ_W      = 2;
    localparam int FRAMES_W   = 14;
    localparam int POS_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // arithmetic widths
    localparam int SCALE_W     = 13;
    localparam int PROD_W      = SR_W + SCALE_W;
    localparam int BAR_FULL_W  = PROD_W + BPB_W;
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    // tempo is in hundredths of a bpm, so frames per beat = rate * 6000 / tempo
    localparam logic [SCALE_W-1:0]  FRAMES_SCALE     = 13'd6000;
    localparam logic [FRAMES_W-1:0] MAX_BLOCK_FRAMES = 14'd8192;
    localparam logic [POS_W-1:0]    POS_MAX          = {POS_W{1'b1}};

    // configuration reset values and the lengths that follow from them
    localparam logic [SR_W-1:0]    SR_RST       = 18'd44100;
    localparam logic [TEMPO_W-1:0] TEMPO_RST    = 17'd12000;
    localparam logic [BPB_W-1:0]   BPB_RST      = 6'd4;
    localparam logic [POS_W-1:0]   BAR_LEN_RST  = 26'd88200;
    localparam logic [POS_W-1:0]   BEAT_LEN_RST = 26'd22050;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_STATUS = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS       = 2'd2;

    // divider request and status
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// File: hw/rtl/mbbc_div.sv
// mbbc_div: restoring divider, one quotient bit per cycle
// 32-bit dividend by 26-bit divisor; uses mbbc_pkg.
module mbbc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbbc_pkg::div_req_t             req,
    output mbbc_pkg::div_sts_t             sts,
    output logic [mbbc_pkg::DIV_W-1:0]     quotient,
    output logic [mbbc_pkg::POS_W-1:0]     remainder
);
    import mbbc_pkg::*;

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [POS_W:0]       shifted;
    logic [POS_W:0]       diff;
    logic                 ge;
    logic                 last;

    // one restoring step: bring in the next dividend bit, try a subtract
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign last    = cnt_reg == DIV_CNT_W'(DIV_W - 1);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[POS_W-1:0] : shifted[POS_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/metronome_bar_beat_counter.sv
// metronome_bar_beat_counter: bar and beat position counter for a metronome
// top level; uses mbbc_pkg and the shared divider mbbc_div.
//
//   channel  signals                                           direction
//   in       in_valid/in_ready, req_type, frames                into block
//   out      out_valid/out_ready, is_running, play_frame,       out of block
//            bar_frames, beat_index, bar_hit, beat_hit, overrun
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data           into block
//
// a tick that looks up the beat waits in S_BEATW for the 32-step shared divider; a
// wrapping tick passes through S_WRAP and S_OVER, and start, stop, status reads and
// stopped ticks go from S_EXEC straight to S_DONE.
// a register write keeps the block busy through two multiplies and up to three
// divider passes (frames per beat, beat length, position reduction).
// one item or write at a time: in_ready and cfg_ready are high only when idle.
// a finished result waits in the output register while out_ready is low.
// reset loads the default rate, tempo and meter with their derived lengths.
module metronome_bar_beat_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mbbc_pkg::REQ_W-1:0]          req_type,
    input  logic [mbbc_pkg::FRAMES_W-1:0]       frames,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                is_running,
    output logic [mbbc_pkg::POS_W-1:0]          play_frame,
    output logic [mbbc_pkg::POS_W-1:0]          bar_frames,
    output logic [mbbc_pkg::BPB_W-1:0]          beat_index,
    output logic                                bar_hit,
    output logic                                beat_hit,
    output logic                                overrun,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mbbc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_WRAP  = 4'd2;
    localparam logic [3:0] S_OVER  = 4'd3;
    localparam logic [3:0] S_BEATW = 4'd4;
    localparam logic [3:0] S_DONE  = 4'd5;
    localparam logic [3:0] S_MUL1  = 4'd6;
    localparam logic [3:0] S_SPB   = 4'd7;
    localparam logic [3:0] S_SPBW  = 4'd8;
    localparam logic [3:0] S_MUL2  = 4'd9;
    localparam logic [3:0] S_BLEN  = 4'd10;
    localparam logic [3:0] S_BLENW = 4'd11;
    localparam logic [3:0] S_RED   = 4'd12;
    localparam logic [3:0] S_REDW  = 4'd13;

    logic [3:0]          state_reg, state_next;
    logic [SR_W-1:0]     sr_reg, sr_next;
    logic [TEMPO_W-1:0]  tempo_reg, tempo_next;
    logic [BPB_W-1:0]    bpb_reg, bpb_next;
    logic [POS_W-1:0]    bar_len_reg, bar_len_next;
    logic [POS_W-1:0]    beat_len_reg, beat_len_next;
    logic                running_reg, running_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BPB_W-1:0]    beat_reg, beat_next;
    logic                bar_flag_reg, bar_flag_next;
    logic                beat_flag_reg, beat_flag_next;
    logic                over_reg, over_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]   spb_reg, spb_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_running_reg, out_running_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [POS_W-1:0]    out_bar_len_reg, out_bar_len_next;
    logic [BPB_W-1:0]    out_beat_reg, out_beat_next;
    logic                out_bar_hit_reg, out_bar_hit_next;
    logic                out_beat_hit_reg, out_beat_hit_next;
    logic                out_over_reg, out_over_next;

    logic [POS_W:0]      pos_sum;
    logic [POS_W-1:0]    pos_sat;
    logic [POS_W-1:0]    pos_dec;
    logic [BAR_FULL_W-1:0] bar_full;
    logic [POS_W-1:0]    bar_sat;
    logic                wrap;
    logic                red_cond;
    logic                beat_div;

    div_req_t            div_req;
    div_sts_t            div_sts;
    logic [DIV_W-1:0]    div_quo;
    logic [POS_W-1:0]    div_rem;

    mbbc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // handshake
    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;

    // tick add with saturation, bar compare, position reduction check
    assign pos_sum  = {1'b0, pos_reg} + (POS_W + 1)'(frames_reg);
    assign pos_sat  = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
    assign pos_dec  = pos_reg - POS_W'(1);
    assign wrap     = pos_reg > bar_len_reg;
    assign beat_div = !wrap && (beat_len_reg != '0);
    assign red_cond = running_reg && (bar_len_reg != '0) && wrap;

    // bar length: frames per beat times beats per bar, saturated
    assign bar_full = spb_reg * bpb_reg;
    assign bar_sat  = (bar_full > BAR_FULL_W'(POS_MAX)) ? POS_MAX : bar_full[POS_W-1:0];

    // divider operand selection
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_SPB:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(prod_reg);
                div_req.divisor  = POS_W'(tempo_reg);
            end
            S_BLEN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(bar_len_reg);
                div_req.divisor  = POS_W'(bpb_reg);
            end
            S_RED:
            begin
                div_req.start    = red_cond;
                div_req.dividend = DIV_W'(pos_dec);
                div_req.divisor  = bar_len_reg;
            end
            S_WRAP:
            begin
                div_req.start    = running_reg && beat_div;
                div_req.dividend = DIV_W'(pos_reg);
                div_req.divisor  = beat_len_reg;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        sr_next           = sr_reg;
        tempo_next        = tempo_reg;
        bpb_next          = bpb_reg;
        bar_len_next      = bar_len_reg;
        beat_len_next     = beat_len_reg;
        running_next      = running_reg;
        pos_next          = pos_reg;
        beat_next         = beat_reg;
        bar_flag_next     = bar_flag_reg;
        beat_flag_next    = beat_flag_reg;
        over_next         = over_reg;
        req_next          = req_reg;
        frames_next       = frames_reg;
        prod_next         = prod_reg;
        spb_next          = spb_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_running_next  = out_running_reg;
        out_pos_next      = out_pos_reg;
        out_bar_len_next  = out_bar_len_reg;
        out_beat_next     = out_beat_reg;
        out_bar_hit_next  = out_bar_hit_reg;
        out_beat_hit_next = out_beat_hit_reg;
        out_over_next     = out_over_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = req_type;
                    frames_next = (frames > MAX_BLOCK_FRAMES) ? MAX_BLOCK_FRAMES : frames;
                    over_next   = 1'b0;
                    state_next  = S_EXEC;
                end
                else if (cfg_valid)
                begin
                    unique case (cfg_index)
                        CFG_SAMPLE_RATE:
                        begin
                            sr_next    = cfg_data[SR_W-1:0];
                            state_next = S_MUL1;
                        end
                        CFG_TEMPO:
                        begin
                            tempo_next = cfg_data[TEMPO_W-1:0];
                            state_next = S_MUL1;
                        end
                        CFG_BEATS:
                        begin
                            // zero beats per bar leaves the register alone
                            if (cfg_data[BPB_W-1:0] != '0)
                            begin
                                bpb_next   = cfg_data[BPB_W-1:0];
                                state_next = S_MUL1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (req_reg)
                    REQ_TICK:
                    begin
                        if (running_reg)
                        begin
                            pos_next   = pos_sat;
                            state_next = S_WRAP;
                        end
                    end
                    REQ_START:
                    begin
                        if (!running_reg && (bar_len_reg != '0))
                        begin
                            running_next  = 1'b1;
                            pos_next      = '0;
                            bar_flag_next = 1'b1;
                        end
                    end
                    REQ_STOP:
                    begin
                        running_next   = 1'b0;
                        pos_next       = '0;
                        bar_flag_next  = 1'b0;
                        beat_flag_next = 1'b0;
                    end
                    REQ_STATUS:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WRAP:
            begin
                // single wrap at bar end, else look up the beat number
                if (wrap)
                begin
                    bar_flag_next = 1'b1;
                    pos_next      = pos_reg - bar_len_reg;
                    state_next    = S_OVER;
                end
                else if (beat_div)
                begin
                    state_next = S_BEATW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_OVER:
            begin
                over_next  = wrap;
                state_next = S_DONE;
            end
            S_BEATW:
            begin
                if (div_sts.done)
                begin
                    if (div_quo[BPB_W-1:0] != beat_reg)
                    begin
                        beat_next      = div_quo[BPB_W-1:0];
                        beat_flag_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_running_next  = running_reg;
                    out_pos_next      = pos_reg;
                    out_bar_len_next  = bar_len_reg;
                    out_beat_next     = beat_reg;
                    out_bar_hit_next  = bar_flag_reg;
                    out_beat_hit_next = beat_flag_reg;
                    out_over_next     = over_reg;
                    if (req_reg == REQ_STATUS)
                    begin
                        bar_flag_next  = 1'b0;
                        beat_flag_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_MUL1:
            begin
                prod_next = PROD_W'(sr_reg) * PROD_W'(FRAMES_SCALE);
                if (tempo_reg == '0)
                begin
                    spb_next   = '0;
                    state_next = S_MUL2;
                end
                else
                begin
                    state_next = S_SPB;
                end
            end
            S_SPB:
            begin
                state_next = S_SPBW;
            end
            S_SPBW:
            begin
                if (div_sts.done)
                begin
                    spb_next   = div_quo[PROD_W-1:0];
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                bar_len_next = bar_sat;
                state_next   = S_BLEN;
            end
            S_BLEN:
            begin
                state_next = S_BLENW;
            end
            S_BLENW:
            begin
                if (div_sts.done)
                begin
                    beat_len_next = div_quo[POS_W-1:0];
                    state_next    = S_RED;
                end
            end
            S_RED:
            begin
                // fold a position beyond the new bar back into it
                state_next = red_cond ? S_REDW : S_IDLE;
            end
            S_REDW:
            begin
                if (div_sts.done)
                begin
                    pos_next   = div_rem + POS_W'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sr_reg        <= SR_RST;
            tempo_reg     <= TEMPO_RST;
            bpb_reg       <= BPB_RST;
            bar_len_reg   <= BAR_LEN_RST;
            beat_len_reg  <= BEAT_LEN_RST;
            running_reg   <= 1'b0;
            pos_reg       <= '0;
            beat_reg      <= '0;
            bar_flag_reg  <= 1'b0;
            beat_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sr_reg        <= sr_next;
            tempo_reg     <= tempo_next;
            bpb_reg       <= bpb_next;
            bar_len_reg   <= bar_len_next;
            beat_len_reg  <= beat_len_next;
            running_reg   <= running_next;
            pos_reg       <= pos_next;
            beat_reg      <= beat_next;
            bar_flag_reg  <= bar_flag_next;
            beat_flag_reg <= beat_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        over_reg         <= over_next;
        req_reg          <= req_next;
        frames_reg       <= frames_next;
        prod_reg         <= prod_next;
        spb_reg          <= spb_next;
        out_running_reg  <= out_running_next;
        out_pos_reg      <= out_pos_next;
        out_bar_len_reg  <= out_bar_len_next;
        out_beat_reg     <= out_beat_next;
        out_bar_hit_reg  <= out_bar_hit_next;
        out_beat_hit_reg <= out_beat_hit_next;
        out_over_reg     <= out_over_next;
    end

    assign out_valid  = out_valid_reg;
    assign is_running = out_running_reg;
    assign play_frame = out_pos_reg;
    assign bar_frames = out_bar_len_reg;
    assign beat_index = out_beat_reg;
    assign bar_hit    = out_bar_hit_reg;
    assign beat_hit   = out_beat_hit_reg;
    assign overrun    = out_over_reg;

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again right after an item");

    // the divider is never restarted while it is still working
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    // a result appears only from the result stage
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the result stage");

    // a stopped metronome always sits at frame zero
    a_stopped_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_running) |-> (play_frame == '0))
        else $error("nonzero position while stopped");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for metronome_bar_beat_counter, covering requests,
// register writes, bar wraps, overruns and a ramp through a saturated bar.
// Depends on mbbc_pkg and the metronome_bar_beat_counter rtl.
`timescale 1ns / 100ps

module tb_top;
    import mbbc_pkg::*;

    localparam int RAND_ITEMS  = 770;
    localparam int RAMP_TICKS  = 150;
    localparam int STALL_LIMIT = 1500;
    localparam int TAIL_CYCLES = 60;

    // register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result item as seen on the output ports
    typedef struct packed {
        logic             running;
        logic [POS_W-1:0] play;
        logic [POS_W-1:0] bar_len;
        logic [BPB_W-1:0] beat;
        logic             bar_hit;
        logic             beat_hit;
        logic             overrun;
    } status_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // one row of the directed plan
    typedef struct {
        row_kind_t             kind;
        logic [REQ_W-1:0]      code;
        logic [CFG_DATA_W-1:0] val;
        bit                    typed;
        status_t               want;
    } plan_row_t;

    localparam status_t IDLE_RST  = '{1'b0, 26'd0, BAR_LEN_RST, 6'd0, 1'b0, 1'b0, 1'b0};
    localparam status_t START_RST = '{1'b1, 26'd0, BAR_LEN_RST, 6'd0, 1'b1, 1'b0, 1'b0};

    // corner values for register writes
    localparam logic [CFG_DATA_W-1:0] RATE_EDGE [4]  = '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF};
    localparam logic [CFG_DATA_W-1:0] TEMPO_EDGE [4] = '{18'd1000, 18'd99900, 18'd0, 18'd1};
    localparam logic [CFG_DATA_W-1:0] BEATS_EDGE [4] = '{18'd1, 18'd32, 18'd0, 18'd63};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [FRAMES_W-1:0]   frames;
    logic                  out_valid;
    logic                  out_ready;
    logic                  is_running;
    logic [POS_W-1:0]      play_frame;
    logic [POS_W-1:0]      bar_frames;
    logic [BPB_W-1:0]      beat_index;
    logic                  bar_hit;
    logic                  beat_hit;
    logic                  overrun;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // counter model state and its settings
    longint unsigned rate_cfg, tempo_cfg, beats_cfg;
    longint unsigned bar_len, beat_len, play_pos;
    logic [BPB_W-1:0] beat_now;
    bit playing, bar_seen, beat_seen;

    status_t status_due[$];
    bit      calm;
    int      errors, items_sent, results_seen, reg_writes, bar_wraps, overruns;
    int      stuck;

    metronome_bar_beat_counter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .frames     (frames),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_running (is_running),
        .play_frame (play_frame),
        .bar_frames (bar_frames),
        .beat_index (beat_index),
        .bar_hit    (bar_hit),
        .beat_hit   (beat_hit),
        .overrun    (overrun),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat and bar lengths from the settings, position folded into the new bar
    function automatic void derive_bar();
        longint unsigned per_beat;
        per_beat = (tempo_cfg != 0) ? (rate_cfg * 6000) / tempo_cfg : 0;
        bar_len  = per_beat * beats_cfg;
        if (bar_len > POS_MAX)
            bar_len = POS_MAX;
        beat_len = bar_len / beats_cfg;
        if (playing && bar_len > 0 && play_pos > bar_len)
            play_pos = ((play_pos - 1) % bar_len) + 1;
    endfunction

    // advance the counter by one request and form its status
    task automatic step_counter(input logic [REQ_W-1:0] req, input logic [FRAMES_W-1:0] frm,
                                output status_t res);
        longint unsigned blk, b;
        bit over;
        blk  = 64'((frm > MAX_BLOCK_FRAMES) ? MAX_BLOCK_FRAMES : frm);
        over = 1'b0;
        case (req)
            REQ_TICK:
            begin
                if (playing)
                begin
                    play_pos = play_pos + blk;
                    if (play_pos > POS_MAX)
                        play_pos = POS_MAX;
                    if (play_pos > bar_len)
                    begin
                        bar_seen = 1'b1;
                        play_pos = play_pos - bar_len;
                        over     = play_pos > bar_len;
                        bar_wraps++;
                        if (over)
                            overruns++;
                    end
                    else if (beat_len > 0)
                    begin
                        b = (play_pos / beat_len) & 64'h3F;
                        if (b != beat_now)
                        begin
                            beat_now  = b[BPB_W-1:0];
                            beat_seen = 1'b1;
                        end
                    end
                end
            end
            REQ_START:
            begin
                if (!playing && bar_len != 0)
                begin
                    playing  = 1'b1;
                    play_pos = 0;
                    bar_seen = 1'b1;
                end
            end
            REQ_STOP:
            begin
                playing   = 1'b0;
                play_pos  = 0;
                bar_seen  = 1'b0;
                beat_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
        res = '{playing, play_pos[POS_W-1:0], bar_len[POS_W-1:0], beat_now,
                bar_seen, beat_seen, over};
        // status read reports the flags, then clears them
        if (req == REQ_STATUS)
        begin
            bar_seen  = 1'b0;
            beat_seen = 1'b0;
        end
    endtask

    // stop offering items until every result has come back
    task automatic settle_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (status_due.size() != 0);
    endtask

    // send one item and queue the status it should produce
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [FRAMES_W-1:0] frm,
                             input bit typed, input status_t want);
        int gap;
        status_t res;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        frames   <= frm;
        do @(posedge clk); while (!in_ready);
        step_counter(req, frm, res);
        status_due.push_back(typed ? want : res);
        items_sent++;
    endtask

    // register write once the block has drained, mirrored into the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        int gap;
        bit known;
        settle_results();
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        known = 1'b1;
        case (idx)
            CFG_SAMPLE_RATE: rate_cfg = 64'(data[SR_W-1:0]);
            CFG_TEMPO:       tempo_cfg = 64'(data[TEMPO_W-1:0]);
            CFG_BEATS:
            begin
                // zero beats per bar leaves the register as it was
                if (data[BPB_W-1:0] != 0)
                    beats_cfg = 64'(data[BPB_W-1:0]);
                else
                    known = 1'b0;
            end
            default:         known = 1'b0;
        endcase
        if (known)
            derive_bar();
        reg_writes++;
    endtask

    task automatic check_field(input string name, input longint unsigned exp,
                               input longint unsigned act);
        if (exp !== act)
        begin
            errors++;
            $display("%0t %s: expected %0d, got %0d", $time, name, exp, act);
        end
    endtask

    // result side: random stalls per item, none while calm is set
    initial
    begin : sink
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // compare each result item with the oldest expected status
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, got play_frame %0d",
                         $time, play_frame);
            end
            else
            begin
                want = status_due.pop_front();
                check_field("is_running", 64'(want.running), 64'(is_running));
                check_field("play_frame", 64'(want.play), 64'(play_frame));
                check_field("bar_frames", 64'(want.bar_len), 64'(bar_frames));
                check_field("beat_index", 64'(want.beat), 64'(beat_index));
                check_field("bar_hit", 64'(want.bar_hit), 64'(bar_hit));
                check_field("beat_hit", 64'(want.beat_hit), 64'(beat_hit));
                check_field("overrun", 64'(want.overrun), 64'(overrun));
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (stuck == STALL_LIMIT)
            begin
                $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
                $display("metronome_bar_beat_counter: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t             plan[$];
        int                    k, span, mode, pick, roll, rand_items;
        logic [REQ_W-1:0]      req;
        logic [FRAMES_W-1:0]   frm;
        logic [CFG_IDX_W-1:0]  idx;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_TICK;
        frames    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SAMPLE_RATE;
        cfg_data  = '0;
        calm      = 1'b0;
        stuck     = 0;

        rate_cfg  = 64'(SR_RST);
        tempo_cfg = 64'(TEMPO_RST);
        beats_cfg = 64'(BPB_RST);
        playing   = 1'b0;
        play_pos  = 0;
        beat_now  = '0;
        bar_seen  = 1'b0;
        beat_seen = 1'b0;
        derive_bar();

        // directed plan: reset state, stopped tick, oversized block, ignored writes,
        // position folding, overrun, zero tempo and rate, extremes, saturated bar
        plan.push_back('{ROW_ITEM, REQ_STATUS, 18'd0, 1'b1, IDLE_RST});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd100, 1'b1, IDLE_RST});
        plan.push_back('{ROW_ITEM, REQ_START, 18'd0, 1'b1, START_RST});
        plan.push_back('{ROW_ITEM, REQ_STATUS, 18'd0, 1'b1, START_RST});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd8192, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd8192, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd16383, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_START, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_STATUS, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_BEATS, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_UNUSED, 18'h2AAAA, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SAMPLE_RATE, 18'd8000, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_STATUS, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TEMPO, 18'd99900, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_BEATS, 18'd1, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd8192, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd1, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_STATUS, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_STOP, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd500, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TEMPO, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_START, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TEMPO, 18'd12000, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SAMPLE_RATE, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_START, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SAMPLE_RATE, 18'd192000, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TEMPO, 18'd1000, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_BEATS, 18'd32, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_START, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd8192, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_TICK, 18'd12345, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_STATUS, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_STOP, 18'd0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SAMPLE_RATE, 18'h3FFFF, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TEMPO, 18'h20001, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_BEATS, 18'h3FFFF, 1'b0, '0});
        plan.push_back('{ROW_ITEM, REQ_START, 18'd0, 1'b0, '0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].code, plan[i].val);
            else
                send_item(plan[i].code, plan[i].val[FRAMES_W-1:0], plan[i].typed, plan[i].want);
        end

        // saturated bar: full blocks back to back across the first beat boundary
        calm = 1'b1;
        for (k = 0; k < RAMP_TICKS; k++)
        begin
            send_item(REQ_TICK, MAX_BLOCK_FRAMES, 1'b0, '0);
            if (k % 32 == 31)
                send_item(REQ_STATUS, '0, 1'b0, '0);
        end
        send_item(REQ_STOP, '0, 1'b0, '0);

        // random phases, each under a fresh setting
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                write_reg(CFG_SAMPLE_RATE, RATE_EDGE[$urandom_range(0, 3)]);
                write_reg(CFG_TEMPO, TEMPO_EDGE[$urandom_range(0, 3)]);
                write_reg(CFG_BEATS, BEATS_EDGE[$urandom_range(0, 3)]);
            end
            else if (mode == 1)
            begin
                for (k = 0; k < 2; k++)
                begin
                    idx = CFG_IDX_W'($urandom_range(0, 3));
                    write_reg(idx, CFG_DATA_W'($urandom()));
                end
            end
            else if (mode <= 3)
            begin
                write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'($urandom_range(8000, 192000)));
                write_reg(CFG_TEMPO, CFG_DATA_W'($urandom_range(1000, 99900)));
                write_reg(CFG_BEATS, CFG_DATA_W'($urandom_range(1, 32)));
            end
            else
            begin
                // short bars so that wraps come often
                write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'($urandom_range(8000, 48000)));
                write_reg(CFG_TEMPO, CFG_DATA_W'($urandom_range(30000, 99900)));
                write_reg(CFG_BEATS, CFG_DATA_W'($urandom_range(1, 4)));
            end
            calm = ($urandom_range(0, 3) == 0);
            span = $urandom_range(20, 80);
            for (k = 0; k < span && rand_items < RAND_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (!playing && roll < 25)
                    req = REQ_START;
                else if (roll < 3)
                    req = REQ_STOP;
                else if (roll < 8)
                    req = REQ_START;
                else if (roll < 30)
                    req = REQ_STATUS;
                else
                    req = REQ_TICK;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    frm = FRAMES_W'($urandom_range(0, 15));
                else if (pick == 1)
                    frm = FRAMES_W'($urandom_range(8193, 16383));
                else if (pick == 2)
                    frm = MAX_BLOCK_FRAMES;
                else
                    frm = FRAMES_W'($urandom_range(0, 8192));
                send_item(req, frm, 1'b0, '0);
                rand_items++;
                if ($urandom_range(0, 39) == 0)
                    settle_results();
            end
        end

        settle_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d items, %0d results, %0d register writes", items_sent,
                 results_seen, reg_writes);
        $display("run: %0d bar wraps, %0d overruns, ramp through a saturated bar done",
                 bar_wraps, overruns);
        if (errors == 0)
            $display("metronome_bar_beat_counter: match");
        else
            $display("metronome_bar_beat_counter: mismatch");
        $finish;
    end

endmodule
